[rtl/sorted_matrix_staircase_search_assert.svh]
// Assertion macros for the sorted matrix staircase search block.
// Uses the module's clk and arst_n; no other dependencies.
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SMS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sorted_matrix_staircase_search: assertion failed");
// Check that cond in one cycle implies res in the next cycle.
`define SMS_ASSERT_NEXT(label, cond, res) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error("sorted_matrix_staircase_search: assertion failed");
`else
`define SMS_ASSERT(label, prop)
`define SMS_ASSERT_NEXT(label, cond, res)
`endif
`endif

[rtl/sms_pkg.sv]
// Package for the sorted matrix staircase search block.
// Holds the sequencer state type; no dependencies.
package sms_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} sms_state_t;

endpackage

[rtl/sorted_matrix_staircase_search.sv]
// Staircase search over a square matrix of signed 32-bit entries whose rows and
// columns increase. Depends on sms_pkg and sorted_matrix_staircase_search_assert.svh.
//
// Usage:
//   Command channel: an item is taken at a rising edge with start high and busy low.
//   func = 0 writes write_value at (write_row, write_col); the write completes in
//   that same edge, gives no result and leaves busy low, so writes may follow every
//   cycle. A write whose row or column reaches SIDE_MAX is dropped.
//   func = 1 searches for key. The walk starts at the top-right corner of the
//   active matrix (matrix_size, saturated at SIDE_MAX) and moves left when key is
//   smaller, down when key is larger, until it hits a match or leaves the matrix.
//   Each visited cell is handled in ST_READ, which reads the matrix memory, then in
//   ST_CMP, which uses the shared signed 32-bit comparator. With N the active side,
//   a search visits at most 2N-1 cells.
//   Result channel: done pulses for exactly one cycle with found, row_found and
//   col_found valid; row and column read zero on a miss. The receiver cannot stall:
//   each result is transferred in the cycle it is shown. busy drops with done, so
//   the next command may be taken in the result cycle.
//   Configuration: size_we writes matrix_size; the user raises it only while the
//   block is idle (not enforced). Reset sets matrix_size to 1 and the sequencer to
//   idle; the matrix memory is not cleared and must be written before it is searched.
module sorted_matrix_staircase_search
	import sms_pkg::*;
#(
	parameter int SIDE_MAX = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               size_we,
	input  logic [4:0]         matrix_size,
	// command
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [3:0]         write_row,
	input  logic [3:0]         write_col,
	input  logic signed [31:0] write_value,
	input  logic signed [31:0] key,
	// result
	output logic               done,
	output logic               found,
	output logic [3:0]         row_found,
	output logic [3:0]         col_found
);

	`include "sorted_matrix_staircase_search_assert.svh"

	localparam int DEPTH = SIDE_MAX * SIDE_MAX;
	localparam int AW    = (SIDE_MAX > 1) ? $clog2(DEPTH) : 1;
	// row and column-remaining counters must hold the side itself
	localparam int CW    = $clog2(SIDE_MAX + 1);
	localparam int XW    = (CW > 4) ? CW : 4;

	sms_state_t state_q, state_d;

	logic [4:0]        matrix_size_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     r_q;
	logic [CW-1:0]     c_q;
	logic signed [31:0] key_q;
	logic signed [31:0] rd_data_q;

	logic signed [31:0] mem [DEPTH];

	logic              done_q, found_q;
	logic [3:0]        row_found_q, col_found_q;

	logic              load, rd_en, step_left, step_down, emit, emit_hit;
	logic              key_lt, key_gt;
	logic [CW-1:0]     col_cur;
	logic [CW-1:0]     n_sat;
	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [XW-1:0]     r_ext, c_ext;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= 5'd1;
		end else if (size_we) begin
			matrix_size_q <= matrix_size;
		end
	end

	// Saturate the active side at SIDE_MAX.
	assign n_sat = (32'(matrix_size_q) > SIDE_MAX) ? CW'(SIDE_MAX) : CW'(matrix_size_q);

	assign col_cur = c_q - CW'(1);

	// Shared comparator: key against the entry just read.
	assign key_lt = key_q < rd_data_q;
	assign key_gt = key_q > rd_data_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		rd_en     = 1'b0;
		step_left = 1'b0;
		step_down = 1'b0;
		emit      = 1'b0;
		emit_hit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && func) begin
					load    = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// off the left edge or past the bottom row: miss
				if (c_q == '0 || r_q >= n_q) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				priority if (key_lt) begin
					step_left = 1'b1;
					state_d   = ST_READ;
				end else if (key_gt) begin
					step_down = 1'b1;
					state_d   = ST_READ;
				end else begin
					emit     = 1'b1;
					emit_hit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Walk position and search operands.
	always_ff @(posedge clk) begin
		if (load) begin
			key_q <= key;
			n_q   <= n_sat;
			r_q   <= '0;
			c_q   <= n_sat;
		end else begin
			if (step_left) c_q <= col_cur;
			if (step_down) r_q <= r_q + CW'(1);
		end
	end

	// Matrix memory: one write port for commands, one registered read port for the walk.
	assign wr_en   = (state_q == ST_IDLE) && start && !func &&
	                 (32'(write_row) < SIDE_MAX) && (32'(write_col) < SIDE_MAX);
	assign wr_addr = AW'(write_row) * AW'(SIDE_MAX) + AW'(write_col);
	assign rd_addr = AW'(r_q) * AW'(SIDE_MAX) + AW'(col_cur);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= write_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Result registers; zero the position on a miss.
	assign r_ext = XW'(r_q);
	assign c_ext = XW'(col_cur);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q     <= emit_hit;
			row_found_q <= emit_hit ? r_ext[3:0] : 4'd0;
			col_found_q <= emit_hit ? c_ext[3:0] : 4'd0;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign found     = found_q;
	assign row_found = row_found_q;
	assign col_found = col_found_q;

	// A result only follows a walk in progress.
	`SMS_ASSERT(a_done_after_walk, done |-> $past(busy))
	// A write never raises busy.
	`SMS_ASSERT_NEXT(a_write_no_busy, start && !busy && !func, !busy)
	// The walk position stays inside the active matrix bounds.
	`SMS_ASSERT(a_walk_bounds, busy |-> (r_q <= n_q) && (c_q <= n_q))
	// A miss reports a zero position.
	`SMS_ASSERT(a_miss_zero, done && !found |-> (row_found == 4'd0) && (col_found == 4'd0))

endmodule

[test/sorted_matrix_staircase_search_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the sorted matrix staircase search block: a queue-fed
// command driver, a result monitor and a staircase-walk predictor of the matrix.
// Depends only on the sorted_matrix_staircase_search RTL and its package.
module sorted_matrix_staircase_search_test;

	localparam int SIDE_MAX    = 16;
	localparam int ITEM_TARGET = 550;
	localparam int CFG_SETTLE  = 4;		// writes finish in their own edge
	localparam int END_SETTLE  = 80;	// longer than the longest walk
	localparam int PRINT_CAP   = 40;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SEARCH = 1'b1
	} op_t;

	typedef struct {
		op_t                op;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] value;
		logic signed [31:0] key;
	} command_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] row;
		logic [3:0] col;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic size_we = 1'b0;
	logic [4:0] matrix_size = 5'd1;
	logic start = 1'b0;
	logic func = 1'b0;
	logic [3:0] write_row = '0;
	logic [3:0] write_col = '0;
	logic signed [31:0] write_value = '0;
	logic signed [31:0] key = '0;
	logic busy;
	logic done;
	logic found;
	logic [3:0] row_found;
	logic [3:0] col_found;

	// Commands waiting for the driver, and the walk outcomes still owed by the block.
	command_t commands[$];
	outcome_t search_outcomes[$];

	// Predictor state, updated at the edge of each transfer.
	logic signed [31:0] tableau [SIDE_MAX][SIDE_MAX];
	logic [4:0] side_cfg;

	// Stimulus-side copy of the matrix, used to build sorted fills and to pick interesting keys.
	logic signed [31:0] plan [SIDE_MAX][SIDE_MAX];
	int plan_side;
	int item_count = 0;
	int mismatch_count = 0;

	// Sender burst shaping.
	int burst_left = 0;
	int gap_left = 0;

	sorted_matrix_staircase_search #(
		.SIDE_MAX(SIDE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.size_we(size_we),
		.matrix_size(matrix_size),
		.start(start),
		.busy(busy),
		.func(func),
		.write_row(write_row),
		.write_col(write_col),
		.write_value(write_value),
		.key(key),
		.done(done),
		.found(found),
		.row_found(row_found),
		.col_found(col_found)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Walk from the top-right corner of the active square: left on smaller,
	// down on larger, stop on the first equal cell or when the walk leaves.
	function automatic outcome_t staircase(logic signed [31:0] target);
		outcome_t res;
		int n;
		int r;
		int c;
		res = '0;
		n = (side_cfg > SIDE_MAX) ? SIDE_MAX : int'(side_cfg);
		r = 0;
		c = n;
		while (c > 0 && r < n && !res.hit) begin
			if (target < tableau[r][c - 1])
				c--;
			else if (target > tableau[r][c - 1])
				r++;
			else begin
				res.hit = 1'b1;
				res.row = r[3:0];
				res.col = c[3:0] - 4'd1;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: %s", $time, what);
	endtask

	// Driver: the edge that sees start high and busy low completes a transfer,
	// so predict from the values still on the ports, then present the next
	// command unless the sender is in a gap.
	always @(posedge clk) begin : drive
		command_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			side_cfg = 5'd1;
		end else begin
			if (size_we)
				side_cfg = matrix_size;
			if (start && !busy) begin
				if (func == OP_WRITE)
					tableau[write_row][write_col] = write_value;
				else
					search_outcomes.push_back(staircase(key));
			end
			// Hold the current command while the block is busy.
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (commands.size() != 0) begin
					nxt = commands.pop_front();
					func <= nxt.op;
					write_row <= nxt.row;
					write_col <= nxt.col;
					write_value <= nxt.value;
					key <= nxt.key;
					start <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						// Mostly short bursts; now and then a long run with no gaps.
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(20, 60) : $urandom_range(0, 6);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else
					start <= 1'b0;
			end
		end
	end

	// Monitor: every done pulse is one transfer; match it to the oldest search.
	always @(posedge clk) begin : watch
		outcome_t want;
		if (arst_n && done) begin
			if (search_outcomes.size() == 0)
				report_mismatch("result transfer with no search outstanding");
			else begin
				want = search_outcomes.pop_front();
				if (found !== want.hit)
					report_mismatch($sformatf("found %b, want %b", found, want.hit));
				if (row_found !== want.row)
					report_mismatch($sformatf("row_found %0d, want %0d", row_found, want.row));
				if (col_found !== want.col)
					report_mismatch($sformatf("col_found %0d, want %0d", col_found, want.col));
			end
		end
	end

	task automatic push_write(int r, int c, logic signed [31:0] v);
		command_t cmd;
		cmd.op = OP_WRITE;
		cmd.row = r[3:0];
		cmd.col = c[3:0];
		cmd.value = v;
		cmd.key = $urandom();
		commands.push_back(cmd);
		plan[r][c] = v;
		item_count++;
	endtask

	task automatic push_search(logic signed [31:0] k);
		command_t cmd;
		cmd.op = OP_SEARCH;
		cmd.row = 4'($urandom_range(0, 15));
		cmd.col = 4'($urandom_range(0, 15));
		cmd.value = $urandom();
		cmd.key = k;
		commands.push_back(cmd);
		item_count++;
	endtask

	// Drain everything queued, then let the block settle.
	task automatic wait_idle(int settle);
		do
			@(negedge clk);
		while (commands.size() != 0 || start || search_outcomes.size() != 0);
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_size(logic [4:0] v);
		wait_idle(CFG_SETTLE);
		@(posedge clk);
		size_we <= 1'b1;
		matrix_size <= v;
		@(posedge clk);
		size_we <= 1'b0;
		@(negedge clk);
		plan_side = (v > SIDE_MAX) ? SIDE_MAX : int'(v);
	endtask

	// Write an n x n square whose rows and columns never decrease. Gaps are
	// bounded so the bottom-right cell still fits in 32 bits.
	task automatic fill_sorted(int n);
		longint gap;
		longint span;
		longint base;
		longint up;
		longint left;
		longint v;
		int r;
		int c;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 26) : $urandom_range(0, 40);
		span = 64'sd4294967295 - longint'(2 * n - 2) * gap;
		if ($urandom_range(0, 7) == 0)
			base = -64'sd2147483648;
		else
			base = -64'sd2147483648 + $urandom_range(0, 32'(span));
		for (r = 0; r < n; r++) begin
			for (c = 0; c < n; c++) begin
				up = (r > 0) ? longint'(plan[r - 1][c]) : base;
				left = (c > 0) ? longint'(plan[r][c - 1]) : base;
				v = (up > left) ? up : left;
				if (r != 0 || c != 0)
					v = v + $urandom_range(0, 32'(gap));
				// Occasionally pin the far corner to the largest value.
				if (r == n - 1 && c == n - 1 && $urandom_range(0, 7) == 0)
					v = S32_MAX;
				push_write(r, c, v[31:0]);
			end
		end
	endtask

	// Keys: mostly cells of the active square, then near misses, extremes and noise.
	function automatic logic signed [31:0] pick_key(int n);
		logic signed [31:0] entry;
		int sel;
		sel = $urandom_range(0, 9);
		entry = (n > 0) ? plan[$urandom_range(0, n - 1)][$urandom_range(0, n - 1)] : $urandom();
		case (sel)
			0, 1, 2, 3, 4: return entry;
			5: return entry + 32'sd1;
			6: return entry - 32'sd1;
			7: return S32_MIN;
			8: return S32_MAX;
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int phase;
		int n;
		logic [4:0] sz;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Size one out of reset: a single cell.
		plan_side = 1;
		push_write(0, 0, 32'sd0);
		push_search(32'sd0);
		push_search(S32_MIN);
		push_search(S32_MAX);
		push_search(-32'sd1);

		// Empty matrix: nothing can be found.
		set_size(5'd0);
		push_search(32'sd0);

		// Two by two with both extremes, plus an entry outside the active square.
		set_size(5'd2);
		push_write(0, 0, S32_MIN);
		push_write(0, 1, -32'sd5);
		push_write(1, 0, 32'sd7);
		push_write(1, 1, S32_MAX);
		push_write(15, 15, 32'sh5A5A_A5A5);
		push_search(S32_MIN);
		push_search(-32'sd5);
		push_search(32'sd7);
		push_search(S32_MAX);
		push_search(32'sd0);
		push_search(32'sd8);
		push_search(-32'sd6);

		// Random phases. The first writes the whole store so that every later
		// size reads only written cells; the second runs past SIDE_MAX.
		phase = 0;
		while (item_count < ITEM_TARGET) begin
			case (phase)
				0: sz = 5'd16;
				1: sz = 5'd31;
				default: begin
					case ($urandom_range(0, 9))
						0: sz = 5'd0;
						1: sz = 5'($urandom_range(17, 31));
						2: sz = 5'd16;
						3: sz = 5'($urandom_range(6, 15));
						default: sz = 5'($urandom_range(1, 5));
					endcase
				end
			endcase
			set_size(sz);
			n = plan_side;
			if (phase == 0 || (n > 0 && n <= 6 && $urandom_range(0, 9) < 7))
				fill_sorted(n);
			repeat ($urandom_range(4, 14)) begin
				// A stray write now and then breaks the ordering on purpose.
				if ($urandom_range(0, 7) == 0)
					push_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom());
				else
					push_search(pick_key(n));
			end
			phase++;
		end

		wait_idle(END_SETTLE);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
